>>> sv/stc_pkg.sv
// Shared types, constants and the sine table for the single tone correlator.
// No dependencies; imported by every module of the block.
package stc_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_WIDTH     = 32;

   localparam int TIME_WIDTH   = 48;
   localparam int STEP_WIDTH   = 32;
   localparam int CSR_WIDTH    = 48;
   localparam int CSR_IDX_BITS = 2;
   localparam int COUNT_WIDTH  = 32;
   localparam int ENTRY_WIDTH  = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int MIX_WIDTH    = SAMPLE_WIDTH + 1;
   localparam int TONE_WIDTH   = 16;
   localparam int PROD_WIDTH   = MIX_WIDTH + TONE_WIDTH;
   localparam int SUM_WIDTH    = 64;
   localparam int RESULT_WIDTH = 32;

   localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
   localparam int QIDX_BITS = SINE_TABLE_BITS - 1;

   localparam int CMD_DEPTH     = 4;
   localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
   localparam int CMD_FILL_BITS = $clog2(CMD_DEPTH + 1);

   localparam int REQ_DATA_WIDTH = 2 * SAMPLE_WIDTH;
   localparam int RSP_DATA_WIDTH = 3 * RESULT_WIDTH + ENTRY_WIDTH;

   localparam logic [CSR_IDX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RESTART_TIME = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CAPTURE_TIME = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_TIME     = 2'd3;

   localparam logic ACTION_AUDIO = 1'b0;
   localparam logic ACTION_REARM = 1'b1;

   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;
   localparam logic [RESULT_WIDTH-1:0] MEAN_LIMIT = 32'd2147450880;

   typedef struct packed {
      logic                         clear;
      logic                         accumulate;
      logic signed [MIX_WIDTH-1:0]  mix;
      logic [SINE_TABLE_BITS-1:0]   phase_index;
      logic                         emit;
      logic [COUNT_WIDTH-1:0]       count;
      logic [ENTRY_WIDTH-1:0]       entry;
   } stc_cmd_type;

   typedef logic [QUARTER:0][TONE_WIDTH-1:0] qsine_table_type;

   // Taylor series of sin(r * pi/2 / QUARTER) in Q30, rounded to 32767 full scale
   function automatic logic [TONE_WIDTH-1:0] quarter_sine(input int unsigned r);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        val;
      logic signed [63:0] s;
      x    = (64'(r) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      s    = signed'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - signed'(term);
         end else begin
            s = s + signed'(term);
         end
      end
      if (s < 0) begin
         s = '0;
      end
      val = (unsigned'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (val > 64'd32767) begin
         val = 64'd32767;
      end
      return val[TONE_WIDTH-1:0];
   endfunction

   function automatic qsine_table_type make_qsine();
      qsine_table_type t;
      for (int r = 0; r <= QUARTER; r++) begin
         t[r] = quarter_sine(r);
      end
      return t;
   endfunction

   localparam qsine_table_type QSINE = make_qsine();

   function automatic logic signed [TONE_WIDTH-1:0] table_sine(
      input logic [SINE_TABLE_BITS-1:0] k
   );
      logic [1:0]            quad;
      logic [QIDX_BITS-1:0]  r;
      logic [TONE_WIDTH-1:0] mag;
      quad = k[SINE_TABLE_BITS-1 -: 2];
      r    = {1'b0, k[SINE_TABLE_BITS-3:0]};
      mag  = quad[0] ? QSINE[QIDX_BITS'(QUARTER) - r] : QSINE[r];
      return quad[1] ? -signed'(mag) : signed'(mag);
   endfunction

endpackage

>>> sv/stc_front.sv
// Front end: configuration registers, sample time, tone phase and count.
// Classifies each request transaction and queues work for the back end; uses stc_pkg.
module stc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [stc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [stc_pkg::CSR_WIDTH-1:0]       csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [stc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   input  logic                                req_tuser,
   output logic                                cmd_push,
   output stc_pkg::stc_cmd_type                cmd_data,
   input  logic                                cmd_full
);
   import stc_pkg::*;

   logic [STEP_WIDTH-1:0]  phase_step_ff;
   logic [TIME_WIDTH-1:0]  restart_time_ff;
   logic [TIME_WIDTH-1:0]  capture_time_ff;
   logic [TIME_WIDTH-1:0]  end_time_ff;
   logic [TIME_WIDTH-1:0]  sample_time_ff;
   logic [PHASE_WIDTH-1:0] tone_phase_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [ENTRY_WIDTH-1:0] entry_ff;
   logic                   finished_ff;

   logic                   accept;
   logic                   running;
   logic                   restart;
   logic                   accumulate;
   logic                   emit;
   logic [TIME_WIDTH-1:0]  sample_time_in;
   logic [PHASE_WIDTH-1:0] phase_base;
   logic [PHASE_WIDTH-1:0] tone_phase_in;
   logic [COUNT_WIDTH-1:0] count_base;
   logic [COUNT_WIDTH-1:0] count_in;
   logic signed [SAMPLE_WIDTH-1:0] left_s;
   logic signed [SAMPLE_WIDTH-1:0] right_s;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign running    = (phase_step_ff != '0) && !finished_ff;
   assign left_s     = signed'(req_tdata[SAMPLE_WIDTH-1:0]);
   assign right_s    = signed'(req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);

   always_comb begin
      restart        = (sample_time_ff == restart_time_ff);
      count_base     = restart ? '0 : count_ff;
      phase_base     = restart ? '0 : tone_phase_ff;
      accumulate     = (capture_time_ff <= sample_time_ff) && (count_base != COUNT_MAX);
      count_in       = count_base + COUNT_WIDTH'(accumulate);
      tone_phase_in  = phase_base + PHASE_WIDTH'(phase_step_ff);
      sample_time_in = sample_time_ff + TIME_WIDTH'(1);
      emit           = (sample_time_in == end_time_ff);

      cmd_data.clear       = restart;
      cmd_data.accumulate  = accumulate;
      cmd_data.mix         = MIX_WIDTH'(left_s) + MIX_WIDTH'(right_s);
      cmd_data.phase_index = phase_base[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
      cmd_data.emit        = emit;
      cmd_data.count       = count_in;
      cmd_data.entry       = entry_ff;

      cmd_push = accept && (req_tuser == ACTION_AUDIO) && running
                 && (restart || accumulate || emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         restart_time_ff <= '0;
         capture_time_ff <= '0;
         end_time_ff     <= '0;
         sample_time_ff  <= '0;
         tone_phase_ff   <= '0;
         count_ff        <= '0;
         entry_ff        <= '0;
         finished_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_PHASE_STEP:   phase_step_ff   <= csr_wdata[STEP_WIDTH-1:0];
               REG_RESTART_TIME: restart_time_ff <= csr_wdata[TIME_WIDTH-1:0];
               REG_CAPTURE_TIME: capture_time_ff <= csr_wdata[TIME_WIDTH-1:0];
               REG_END_TIME:     end_time_ff     <= csr_wdata[TIME_WIDTH-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            if (req_tuser == ACTION_REARM) begin
               finished_ff <= 1'b0;
            end else if (running) begin
               sample_time_ff <= sample_time_in;
               tone_phase_ff  <= tone_phase_in;
               count_ff       <= count_in;
               if (emit) begin
                  entry_ff    <= entry_ff + ENTRY_WIDTH'(1);
                  finished_ff <= 1'b1;
               end
            end
         end
      end
   end

endmodule

>>> sv/stc_fifo.sv
// Short command queue between the front end and the back end.
// Register based, first in first out; uses stc_pkg.
module stc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stc_pkg::stc_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output stc_pkg::stc_cmd_type head_data,
   output logic                 empty
);
   import stc_pkg::*;

   stc_cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0]  wr_ptr_ff;
   logic [CMD_PTR_BITS-1:0]  rd_ptr_ff;
   logic [CMD_FILL_BITS-1:0] fill_ff;

   assign full      = (fill_ff == CMD_FILL_BITS'(CMD_DEPTH));
   assign empty     = (fill_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                         : wr_ptr_ff + CMD_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == CMD_PTR_BITS'(CMD_DEPTH - 1)) ? '0
                         : rd_ptr_ff + CMD_PTR_BITS'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + CMD_FILL_BITS'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - CMD_FILL_BITS'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("command popped from an empty queue");

endmodule

>>> sv/stc_back.sv
// Back end: tone lookup, products, 64-bit sums and the mean division.
// Pops commands from stc_fifo and drives the response channel; uses stc_pkg.
module stc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  stc_pkg::stc_cmd_type                head_data,
   input  logic                                empty,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tuser
);
   import stc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_PREP = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   localparam int STEP_BITS = $clog2(RESULT_WIDTH);

   logic [2:0]                     state_ff;
   logic [2:0]                     state_in;
   stc_cmd_type                    cmd_ff;
   logic signed [TONE_WIDTH-1:0]   sine_ff;
   logic signed [TONE_WIDTH-1:0]   cosine_ff;
   logic signed [PROD_WIDTH-1:0]   prod_sin_ff;
   logic signed [PROD_WIDTH-1:0]   prod_cos_ff;
   logic [SUM_WIDTH-1:0]           sum_sin_ff;
   logic [SUM_WIDTH-1:0]           sum_cos_ff;
   logic                           neg_sin_ff;
   logic                           neg_cos_ff;
   logic [COUNT_WIDTH-1:0]         rem_sin_ff;
   logic [COUNT_WIDTH-1:0]         rem_cos_ff;
   logic [RESULT_WIDTH-1:0]        quo_sin_ff;
   logic [RESULT_WIDTH-1:0]        quo_cos_ff;
   logic [STEP_BITS-1:0]           step_ff;
   logic                           rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0]      rsp_data_ff;
   logic                           rsp_user_ff;

   logic signed [MIX_WIDTH-1:0]    mix;
   logic [SUM_WIDTH-1:0]           base_sin;
   logic [SUM_WIDTH-1:0]           base_cos;
   logic [SUM_WIDTH-1:0]           mag_sin;
   logic [SUM_WIDTH-1:0]           mag_cos;
   logic [COUNT_WIDTH:0]           trial_sin;
   logic [COUNT_WIDTH:0]           trial_cos;
   logic                           fit_sin;
   logic                           fit_cos;
   logic [RESULT_WIDTH-1:0]        lim_sin;
   logic [RESULT_WIDTH-1:0]        lim_cos;
   logic [RESULT_WIDTH-1:0]        out_real;
   logic [RESULT_WIDTH-1:0]        out_imag;
   logic                           load;

   assign mix      = cmd_ff.mix;
   assign pop      = (state_ff == ST_IDLE) && !empty;
   assign load     = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_tready);
   assign base_sin = cmd_ff.clear ? '0 : sum_sin_ff;
   assign base_cos = cmd_ff.clear ? '0 : sum_cos_ff;
   assign mag_sin  = sum_sin_ff[SUM_WIDTH-1] ? -sum_sin_ff : sum_sin_ff;
   assign mag_cos  = sum_cos_ff[SUM_WIDTH-1] ? -sum_cos_ff : sum_cos_ff;

   // restoring division, one quotient bit per cycle; the mean fits in 32 bits
   assign trial_sin = {rem_sin_ff, quo_sin_ff[RESULT_WIDTH-1]};
   assign trial_cos = {rem_cos_ff, quo_cos_ff[RESULT_WIDTH-1]};
   assign fit_sin   = (trial_sin >= {1'b0, cmd_ff.count});
   assign fit_cos   = (trial_cos >= {1'b0, cmd_ff.count});

   always_comb begin
      lim_sin  = (quo_sin_ff > MEAN_LIMIT) ? MEAN_LIMIT : quo_sin_ff;
      lim_cos  = (quo_cos_ff > MEAN_LIMIT) ? MEAN_LIMIT : quo_cos_ff;
      out_real = neg_sin_ff ? -lim_sin : lim_sin;
      out_imag = neg_cos_ff ? -lim_cos : lim_cos;
      if (cmd_ff.count == '0) begin
         out_real = '0;
         out_imag = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!empty) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (!cmd_ff.emit) begin
               state_in = ST_IDLE;
            end else if (cmd_ff.count == '0) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (step_ff == STEP_BITS'(RESULT_WIDTH - 1)) state_in = ST_LOAD;
         ST_LOAD: if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_sin_ff   <= '0;
         sum_cos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_ACC) begin
            sum_sin_ff <= base_sin + (cmd_ff.accumulate
               ? {{(SUM_WIDTH-PROD_WIDTH){prod_sin_ff[PROD_WIDTH-1]}}, prod_sin_ff} : '0);
            sum_cos_ff <= base_cos + (cmd_ff.accumulate
               ? {{(SUM_WIDTH-PROD_WIDTH){prod_cos_ff[PROD_WIDTH-1]}}, prod_cos_ff} : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (!empty) cmd_ff <= head_data;
         ST_LOOK: begin
            sine_ff   <= table_sine(cmd_ff.phase_index);
            cosine_ff <= table_sine(cmd_ff.phase_index
                                    + SINE_TABLE_BITS'(QUARTER));
         end
         ST_MUL: begin
            prod_sin_ff <= mix * sine_ff;
            prod_cos_ff <= mix * cosine_ff;
         end
         ST_PREP: begin
            neg_sin_ff <= sum_sin_ff[SUM_WIDTH-1];
            neg_cos_ff <= sum_cos_ff[SUM_WIDTH-1];
            rem_sin_ff <= mag_sin[SUM_WIDTH-1:RESULT_WIDTH];
            rem_cos_ff <= mag_cos[SUM_WIDTH-1:RESULT_WIDTH];
            quo_sin_ff <= mag_sin[RESULT_WIDTH-1:0];
            quo_cos_ff <= mag_cos[RESULT_WIDTH-1:0];
            step_ff    <= '0;
         end
         ST_DIV: begin
            rem_sin_ff <= fit_sin ? COUNT_WIDTH'(trial_sin - {1'b0, cmd_ff.count})
                                  : trial_sin[COUNT_WIDTH-1:0];
            rem_cos_ff <= fit_cos ? COUNT_WIDTH'(trial_cos - {1'b0, cmd_ff.count})
                                  : trial_cos[COUNT_WIDTH-1:0];
            quo_sin_ff <= {quo_sin_ff[RESULT_WIDTH-2:0], fit_sin};
            quo_cos_ff <= {quo_cos_ff[RESULT_WIDTH-2:0], fit_cos};
            step_ff    <= step_ff + STEP_BITS'(1);
         end
         default: ;
      endcase
      if (load) begin
         rsp_data_ff <= {cmd_ff.entry, cmd_ff.count, out_imag, out_real};
         rsp_user_ff <= (cmd_ff.count == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOAD)
      else $error("response raised outside the load step");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cmd_ff.count != '0))
      else $error("division started with a zero count");
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP) |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("division did not start from step zero");

endmodule

>>> sv/single_tone_correlator.sv
// Single tone correlator: correlates the left plus right sum of each audio frame
// against the sine and cosine of a numerically controlled tone and reports the two
// means at the end time. A frame is accepted whenever the four-entry command queue
// has room; frames that change the sums pass through the pop, tone table lookup,
// multiply and accumulate states of the back end, which works on one frame at a time.
// Dropped frames and rearm transactions never enter the queue. The frame that ends an
// entry with a nonzero count then passes the 32-step shift-subtract divider that forms
// both means in parallel, before its result enters the output register.
// Depends on stc_pkg, stc_front, stc_fifo and stc_back.
module single_tone_correlator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [stc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [stc_pkg::CSR_WIDTH-1:0]       csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // left_sample[15:0], right_sample[31:16]
   input  logic [stc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_real[31:0], result_imag[63:32], sample_count[95:64], entry_number[103:96]
   output logic [stc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // no_samples
   output logic                                rsp_tuser
);
   import stc_pkg::*;

   logic        cmd_push;
   stc_cmd_type cmd_data;
   logic        cmd_full;
   logic        cmd_pop;
   stc_cmd_type cmd_head;
   logic        cmd_empty;

   stc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_data),
      .cmd_full   (cmd_full)
   );

   stc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .empty     (cmd_empty)
   );

   stc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (cmd_head),
      .empty      (cmd_empty),
      .pop        (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> test/single_tone_correlator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for single_tone_correlator: stereo frames and rearm transactions
// in, measurement results out, checked against an in-bench model of the correlator.
// Depends on stc_pkg and the single_tone_correlator RTL.
module single_tone_correlator_test;
   import stc_pkg::*;

   localparam int          LUT_SIZE     = 1 << SINE_TABLE_BITS;
   localparam longint      PI_HALF_Q30  = 64'd1686629713;
   localparam int          ITEM_TARGET  = 950;
   localparam int          QUIET_AFTER  = 820;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          IDLE_LIMIT   = 20000;
   localparam int          ERROR_PRINTS = 40;

   typedef struct packed {
      logic                    action;
      logic [SAMPLE_WIDTH-1:0] left;
      logic [SAMPLE_WIDTH-1:0] right;
   } frame_item_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] mean_sin;
      logic [RESULT_WIDTH-1:0] mean_cos;
      logic [COUNT_WIDTH-1:0]  count;
      logic                    no_samples;
      logic [ENTRY_WIDTH-1:0]  entry;
   } entry_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [CSR_WIDTH-1:0]        csr_wdata = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // left_sample[15:0], right_sample[31:16]
   logic [REQ_DATA_WIDTH-1:0]   req_tdata = '0;
   // action
   logic                        req_tuser = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   // result_real[31:0], result_imag[63:32], sample_count[95:64], entry_number[103:96]
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   // no_samples
   logic                        rsp_tuser;

   single_tone_correlator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("single_tone_correlator: mismatch");
      $finish;
   end

   // correlator model state
   logic signed [TONE_WIDTH-1:0] tone_lut [0:LUT_SIZE-1];
   logic [STEP_WIDTH-1:0]  cfg_step = '0;
   logic [TIME_WIDTH-1:0]  cfg_restart = '0;
   logic [TIME_WIDTH-1:0]  cfg_capture = '0;
   logic [TIME_WIDTH-1:0]  cfg_end = '0;
   logic [TIME_WIDTH-1:0]  now_time = '0;
   logic [PHASE_WIDTH-1:0] phase_acc = '0;
   logic [COUNT_WIDTH-1:0] frame_count = '0;
   longint                 sum_sin = 0;
   longint                 sum_cos = 0;
   logic [ENTRY_WIDTH-1:0] entry_no = '0;
   logic                   awaiting_rearm = 1'b0;

   frame_item_type   send_queue [$];
   entry_result_type predicted [$];
   int               errors = 0;
   int               items_queued = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;
   bit               quiet = 1'b0;
   bit               in_flight = 1'b0;
   frame_item_type   cur_item;
   int               send_gap = 0;
   int               stall_left = 0;

   function automatic int quarter_value(input int r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned val;
      longint          s;
      x    = (longint'(r) * PI_HALF_Q30) >> (SINE_TABLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - longint'(term);
         end else begin
            s = s + longint'(term);
         end
      end
      if (s < 0) begin
         s = 0;
      end
      val = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (val > 64'd32767) begin
         val = 64'd32767;
      end
      return int'(val);
   endfunction

   function automatic logic [RESULT_WIDTH-1:0] mean_of(input longint sum,
                                                       input logic [COUNT_WIDTH-1:0] cnt);
      logic [63:0] bits;
      logic [63:0] mag;
      logic [63:0] q;
      bits = sum;
      mag  = bits[63] ? (~bits + 64'd1) : bits;
      q    = mag / {32'd0, cnt};
      if (q > {32'd0, MEAN_LIMIT}) begin
         q = {32'd0, MEAN_LIMIT};
      end
      return bits[63] ? -q[RESULT_WIDTH-1:0] : q[RESULT_WIDTH-1:0];
   endfunction

   function automatic void correlate_frame(input frame_item_type item);
      int                         mix;
      logic [SINE_TABLE_BITS-1:0] k;
      logic [SINE_TABLE_BITS-1:0] kc;
      entry_result_type           res;
      if (item.action == ACTION_REARM) begin
         awaiting_rearm = 1'b0;
         return;
      end
      if (cfg_step == '0 || awaiting_rearm) begin
         return;
      end
      if (now_time == cfg_restart) begin
         phase_acc   = '0;
         frame_count = '0;
         sum_sin     = 0;
         sum_cos     = 0;
      end
      if (cfg_capture <= now_time && frame_count != COUNT_MAX) begin
         mix = int'($signed(item.left)) + int'($signed(item.right));
         k   = phase_acc[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
         kc  = k + SINE_TABLE_BITS'(QUARTER);
         sum_sin = sum_sin + longint'(mix) * longint'(tone_lut[k]);
         sum_cos = sum_cos + longint'(mix) * longint'(tone_lut[kc]);
         frame_count = frame_count + 1'b1;
      end
      phase_acc = phase_acc + cfg_step;
      now_time  = now_time + 1'b1;
      if (now_time == cfg_end) begin
         if (frame_count == '0) begin
            res = '{'0, '0, '0, 1'b1, entry_no};
         end else begin
            res = '{mean_of(sum_sin, frame_count), mean_of(sum_cos, frame_count),
                    frame_count, 1'b0, entry_no};
         end
         predicted.push_back(res);
         entry_no       = entry_no + 1'b1;
         awaiting_rearm = 1'b1;
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= ERROR_PRINTS) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            correlate_frame(cur_item);
            in_flight = 1'b0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (send_queue.size() > 0) begin
            cur_item  = send_queue.pop_front();
            in_flight = 1'b1;
            req_tvalid <= 1'b1;
            req_tdata  <= {cur_item.right, cur_item.left};
            req_tuser  <= cur_item.action;
            if (!quiet && $urandom_range(99) < gap_pct) begin
               send_gap = $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      entry_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted.size() == 0) begin
               errors++;
               if (errors <= ERROR_PRINTS) begin
                  $display("%0t: no result expected, got %h / %b", $time, rsp_tdata,
                           rsp_tuser);
               end
            end else begin
               want = predicted.pop_front();
               compare_field("result_real", want.mean_sin, rsp_tdata[31:0]);
               compare_field("result_imag", want.mean_cos, rsp_tdata[63:32]);
               compare_field("sample_count", want.count, rsp_tdata[95:64]);
               compare_field("no_samples", 32'(want.no_samples), 32'(rsp_tuser));
               compare_field("entry_number", 32'(want.entry), 32'(rsp_tdata[103:96]));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(99) < stall_pct) begin
               stall_left = $urandom_range(1, 12);
            end
         end
      end
   end

   function automatic void queue_item(input logic action, input logic [15:0] left,
                                      input logic [15:0] right);
      send_queue.push_back('{action, left, right});
      items_queued++;
   endfunction

   function automatic logic [15:0] any_sample();
      case ($urandom_range(11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void queue_frames(input int n);
      for (int i = 0; i < n; i++) begin
         queue_item(ACTION_AUDIO, any_sample(), any_sample());
      end
   endfunction

   function automatic void queue_rearm();
      queue_item(ACTION_REARM, 16'($urandom), 16'($urandom));
   endfunction

   function automatic logic [TIME_WIDTH-1:0] any_time();
      return {16'($urandom), $urandom};
   endfunction

   // wait until every transaction is through and every result is in
   task automatic settle();
      int n;
      n = 0;
      while ((send_queue.size() != 0 || in_flight || predicted.size() != 0)
             && n < IDLE_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (predicted.size() != 0) begin
         errors += predicted.size();
         $display("%0t: %0d results missing, expected %h, got none", $time,
                  predicted.size(), predicted[0]);
         predicted.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_PHASE_STEP:   cfg_step    = value[STEP_WIDTH-1:0];
         REG_RESTART_TIME: cfg_restart = value[TIME_WIDTH-1:0];
         REG_CAPTURE_TIME: cfg_capture = value[TIME_WIDTH-1:0];
         REG_END_TIME:     cfg_end     = value[TIME_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic program_entry(input logic [CSR_WIDTH-1:0] step,
                                input logic [TIME_WIDTH-1:0] restart,
                                input logic [TIME_WIDTH-1:0] capture,
                                input logic [TIME_WIDTH-1:0] finish);
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_RESTART_TIME, restart);
      write_reg(REG_CAPTURE_TIME, capture);
      write_reg(REG_END_TIME, finish);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int                     qv [0:QUARTER];
      int                     quad;
      int                     r;
      int                     n;
      logic [CSR_WIDTH-1:0]   step;
      logic [TIME_WIDTH-1:0]  restart;
      logic [TIME_WIDTH-1:0]  capture;
      logic [TIME_WIDTH-1:0]  finish;
      for (int i = 0; i <= QUARTER; i++) begin
         qv[i] = quarter_value(i);
      end
      for (int k = 0; k < LUT_SIZE; k++) begin
         quad = k / QUARTER;
         r    = k % QUARTER;
         n    = (quad % 2 == 1) ? qv[QUARTER - r] : qv[r];
         tone_lut[k] = TONE_WIDTH'((quad >= 2) ? -n : n);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // inactive after reset: frames dropped, rearm harmless
      queue_item(ACTION_AUDIO, 16'h7FFF, 16'h8000);
      queue_item(ACTION_AUDIO, 16'h8000, 16'h7FFF);
      queue_rearm();

      // quarter-cycle tone, full-scale samples, then a frame while waiting for rearm
      settle();
      program_entry(48'h0000_4000_0000, now_time, now_time, now_time + 4);
      queue_rearm();
      queue_item(ACTION_AUDIO, 16'h7FFF, 16'h7FFF);
      queue_item(ACTION_AUDIO, 16'h8000, 16'h8000);
      queue_item(ACTION_AUDIO, 16'h7FFF, 16'h8000);
      queue_item(ACTION_AUDIO, 16'h8000, 16'h7FFF);
      queue_item(ACTION_AUDIO, 16'h0000, 16'h0000);

      // capture after end: no samples; step written with upper bits set
      settle();
      program_entry(48'hFFFF_FFFF_FFFF, now_time, now_time + 50, now_time + 2);
      queue_rearm();
      queue_frames(2);

      // restart in the middle of the entry
      settle();
      program_entry(48'hABCD_1234_5679, now_time + 2, now_time, now_time + 5);
      queue_rearm();
      queue_frames(5);

      // no restart: sums carry over from the previous entry; double rearm
      settle();
      program_entry(48'h0000_0010_0001, now_time + 100, '0, now_time + 3);
      queue_rearm();
      queue_rearm();
      queue_frames(3);

      while (items_queued < ITEM_TARGET) begin
         settle();
         if (items_queued >= QUIET_AFTER) begin
            quiet = 1'b1;
         end
         gap_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
         stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
         n = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
         case ($urandom_range(15))
            0:       step = '0;
            1:       step = '1;
            2:       step = CSR_WIDTH'($urandom_range(1, 255));
            default: step = any_time();
         endcase
         case ($urandom_range(7))
            4:       restart = now_time + TIME_WIDTH'($urandom_range(0, n));
            5:       restart = any_time();
            6:       restart = now_time - 1;
            7:       restart = now_time + TIME_WIDTH'(n + 5);
            default: restart = now_time;
         endcase
         case ($urandom_range(7))
            4:       capture = now_time + TIME_WIDTH'($urandom_range(0, n));
            5:       capture = '0;
            6:       capture = any_time();
            7:       capture = '1;
            default: capture = now_time;
         endcase
         case ($urandom_range(23))
            0:       finish = now_time;
            1, 2:    finish = any_time();
            default: finish = now_time + TIME_WIDTH'(n);
         endcase
         program_entry(step, restart, capture, finish);
         if ($urandom_range(5) == 0) begin
            queue_frames(1);
         end
         queue_rearm();
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) begin
               queue_rearm();
            end
            queue_frames(1);
         end
         queue_frames($urandom_range(0, 2));
      end

      settle();
      if (errors == 0) begin
         $display("single_tone_correlator: match");
      end else begin
         $display("single_tone_correlator: mismatch");
      end
      $finish;
   end

endmodule

>>> single_tone_correlator.f
sv/stc_pkg.sv
sv/stc_front.sv
sv/stc_fifo.sv
sv/stc_back.sv
sv/single_tone_correlator.sv
test/single_tone_correlator_test.sv
